// ----- design/btc_pkg.sv -----
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and constants for the block to CHS task-file translator.
// ----------------------------------------------------------------------------
package btc_pkg;

    localparam int OPCODE_W = 2;
    localparam int MINOR_W  = 7;
    localparam int SECTOR_W = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;
    localparam int SPT_W    = 8;
    localparam int HEADS_W  = 5;
    localparam int CYL_W    = 16;
    localparam int HEAD_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // absolute block is a 33-bit sum
    localparam int BLOCK_W   = SECTOR_W + 1;
    localparam int DIV_STEPS = BLOCK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVFL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT_D0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS_D0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT_D1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS_D1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PCOMP_D0 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PCOMP_D1 = 3'd6;

    localparam logic [SPT_W-1:0]   SPT_RESET   = 8'd17;
    localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd4;
    localparam logic [HEADS_W-1:0] HEADS_MAX   = 5'd16;
    localparam logic [BYTE_W-1:0]  DRIVE_HEAD_BASE = 8'hA0;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                drive_index;
        logic [BYTE_W-1:0]   sector_number;
        logic [HEAD_W-1:0]   head_number;
        logic [CYL_W-1:0]    cylinder_number;
        logic [BYTE_W-1:0]   precomp_byte;
        logic [BYTE_W-1:0]   count_byte;
        logic [BYTE_W-1:0]   drive_head_byte;
        logic                is_write;
    } res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/btc_if.sv -----
// ----------------------------------------------------------------------------
// btc_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface btc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [6:0]  minor_number;
    logic [31:0] request_sector;
    logic [7:0]  sector_count;
    logic [31:0] part_start;
    logic [31:0] part_size;

    modport source (output valid, output opcode, output minor_number,
                    output request_sector, output sector_count,
                    output part_start, output part_size, input ready);
    modport sink   (input valid, input opcode, input minor_number,
                    input request_sector, input sector_count,
                    input part_start, input part_size, output ready);
endinterface

interface btc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        drive_index;
    logic [7:0]  sector_number;
    logic [3:0]  head_number;
    logic [15:0] cylinder_number;
    logic [7:0]  precomp_byte;
    logic [7:0]  count_byte;
    logic [7:0]  drive_head_byte;
    logic        is_write;

    modport source (output valid, output status, output drive_index,
                    output sector_number, output head_number,
                    output cylinder_number, output precomp_byte,
                    output count_byte, output drive_head_byte,
                    output is_write, input ready);
    modport sink   (input valid, input status, input drive_index,
                    input sector_number, input head_number,
                    input cylinder_number, input precomp_byte,
                    input count_byte, input drive_head_byte,
                    input is_write, output ready);
endinterface

// ----- design/block_to_chs_task_file_top.sv -----
// ----------------------------------------------------------------------------
// block_to_chs_task_file_top
// Partition table lookup and block to CHS translation with task-file bytes.
//
//   channel  dir   kind                 contents
//   req      in    valid/ready          opcode, minor, sector, count, load data
//   rsp      out   valid/ready          status, CHS, task-file bytes
//   cfg      in    write enable/index   geometry, precomp and drive count
//
// A load or unknown opcode goes from accept straight to S_FINISH and the
// response register, a rejected request by way of S_CHECK. A translated
// request passes table read and check, then two 33-step passes of the
// shared bit-serial divider (by sectors per track, by heads).
// One transaction is in work at a time; the next request is taken the cycle
// after the result is registered, even while it waits in the output
// register. A result that finds that register still full holds the input.
// Reset clears the partition size valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module block_to_chs_task_file_top #(
    parameter int PARTS_PER_DRIVE = 64,
    parameter int MAX_DRIVES      = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    btc_req_if.sink                       req,
    btc_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import btc_pkg::*;

    localparam int DEPTH = MAX_DRIVES * PARTS_PER_DRIVE;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_SEC,
        S_DIV_HEAD,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [OPCODE_W-1:0]   opcode_reg;
    logic [MINOR_W-1:0]    minor_reg;
    logic [SECTOR_W-1:0]   sector_reg;
    logic [COUNT_W-1:0]    count_reg;
    res_t                  res_reg;
    res_t                  rsp_reg;
    logic                  rsp_valid_reg;

    logic [1:0]            drives_reg;
    logic [SPT_W-1:0]      spt_d0_reg;
    logic [HEADS_W-1:0]    heads_d0_reg;
    logic [SPT_W-1:0]      spt_d1_reg;
    logic [HEADS_W-1:0]    heads_d1_reg;
    logic [CYL_W-1:0]      pcomp_d0_reg;
    logic [CYL_W-1:0]      pcomp_d1_reg;

    logic                  req_acc;
    logic                  tbl_wr;
    logic [SECTOR_W-1:0]   tbl_start;
    logic [SECTOR_W-1:0]   tbl_size;
    logic [1:0]            drive_code;
    logic                  drive_sel;
    logic [SPT_W-1:0]      spt_raw;
    logic [SPT_W-1:0]      spt_eff;
    logic [HEADS_W-1:0]    heads_raw;
    logic [HEADS_W-1:0]    heads_eff;
    logic [CYL_W-1:0]      pcomp;
    logic                  reject;
    logic [BLOCK_W-1:0]    block;

    logic                  div_start;
    logic [BLOCK_W-1:0]    div_dividend;
    logic [SPT_W-1:0]      div_divisor;
    logic [BLOCK_W-1:0]    div_quot;
    logic [SPT_W-1:0]      div_rem;
    div_stat_t             div_stat;

    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign tbl_wr    = req_acc && (req.opcode == OP_LOAD)
                       && ({1'b0, req.minor_number} < 8'(DEPTH));

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drives_reg   <= '0;
            spt_d0_reg   <= SPT_RESET;
            heads_d0_reg <= HEADS_RESET;
            spt_d1_reg   <= SPT_RESET;
            heads_d1_reg <= HEADS_RESET;
            pcomp_d0_reg <= '0;
            pcomp_d1_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DRIVES:   drives_reg   <= cfg_wdata[1:0];
                CFG_SPT_D0:   spt_d0_reg   <= cfg_wdata[SPT_W-1:0];
                CFG_HEADS_D0: heads_d0_reg <= cfg_wdata[HEADS_W-1:0];
                CFG_SPT_D1:   spt_d1_reg   <= cfg_wdata[SPT_W-1:0];
                CFG_HEADS_D1: heads_d1_reg <= cfg_wdata[HEADS_W-1:0];
                CFG_PCOMP_D0: pcomp_d0_reg <= cfg_wdata;
                CFG_PCOMP_D1: pcomp_d1_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ----------------------------------------------------------------- table
    btc_table #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr),
        .wr_addr  (req.minor_number[IDX_W-1:0]),
        .wr_start (req.part_start),
        .wr_size  (req.part_size),
        .rd_en    (req_acc),
        .rd_addr  (req.minor_number[IDX_W-1:0]),
        .rd_start (tbl_start),
        .rd_size  (tbl_size)
    );

    // -------------------------------------------------------------- geometry
    // drive number saturated at 2; anything at 2 or above is rejected
    assign drive_code = ({1'b0, minor_reg} < 8'(PARTS_PER_DRIVE))     ? 2'd0 :
                        ({1'b0, minor_reg} < 8'(2 * PARTS_PER_DRIVE)) ? 2'd1 : 2'd2;
    assign drive_sel  = drive_code[0];
    assign spt_raw    = (drive_code == 2'd0) ? spt_d0_reg   : spt_d1_reg;
    assign heads_raw  = (drive_code == 2'd0) ? heads_d0_reg : heads_d1_reg;
    assign pcomp      = (drive_code == 2'd0) ? pcomp_d0_reg : pcomp_d1_reg;
    assign spt_eff    = (spt_raw == '0) ? SPT_W'(1) : spt_raw;
    assign heads_eff  = (heads_raw == '0)      ? HEADS_W'(1) :
                        (heads_raw > HEADS_MAX) ? HEADS_MAX   : heads_raw;

    assign reject = (drive_code >= drives_reg)
                    || (drive_code >= 2'(MAX_DRIVES))
                    || ({1'b0, minor_reg} >= 8'(DEPTH))
                    || (sector_reg >= tbl_size);
    assign block  = {1'b0, sector_reg} + {1'b0, tbl_start};

    // --------------------------------------------------------------- divider
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = block;
        div_divisor  = spt_eff;
        if (state_reg == S_CHECK && !reject)
            div_start = 1'b1;
        else if (state_reg == S_DIV_SEC && div_stat.done)
        begin
            div_start    = 1'b1;
            div_dividend = div_quot;
            div_divisor  = {3'b0, heads_eff};
        end
    end

    btc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quot),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // --------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            opcode_reg    <= '0;
            minor_reg     <= '0;
            sector_reg    <= '0;
            count_reg     <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.ready && state_reg != S_FINISH)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_acc)
                    begin
                        opcode_reg <= req.opcode;
                        minor_reg  <= req.minor_number;
                        sector_reg <= req.request_sector;
                        count_reg  <= req.sector_count;
                        case (req.opcode) inside
                            OP_LOAD:
                            begin
                                res_reg   <= '{status: (tbl_wr ? ST_LOADED : ST_RANGE),
                                               default: '0};
                                state_reg <= S_FINISH;
                            end
                            OP_READ, OP_WRITE:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_CHECK;
                            end
                            default:
                            begin
                                res_reg   <= '{status: ST_RANGE, default: '0};
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_CHECK:
                begin
                    res_reg <= '{status: (reject ? ST_RANGE : ST_OK),
                                 is_write: (opcode_reg == OP_WRITE),
                                 default: '0};
                    if (reject)
                        state_reg <= S_FINISH;
                    else
                        state_reg <= S_DIV_SEC;
                end
                S_DIV_SEC:
                begin
                    if (div_stat.done)
                    begin
                        res_reg.sector_number <= div_rem + 1'b1;
                        state_reg             <= S_DIV_HEAD;
                    end
                end
                S_DIV_HEAD:
                begin
                    if (div_stat.done)
                    begin
                        res_reg.drive_index <= drive_sel;
                        if (div_quot[BLOCK_W-1:CYL_W] != '0)
                        begin
                            res_reg.status        <= ST_OVFL;
                            res_reg.sector_number <= '0;
                        end
                        else
                        begin
                            res_reg.status          <= ST_OK;
                            res_reg.head_number     <= div_rem[HEAD_W-1:0];
                            res_reg.cylinder_number <= div_quot[CYL_W-1:0];
                            res_reg.precomp_byte    <= pcomp[BYTE_W+1:2];
                            res_reg.count_byte      <= count_reg;
                            res_reg.drive_head_byte <= DRIVE_HEAD_BASE
                                | {3'b0, drive_sel, div_rem[HEAD_W-1:0]};
                        end
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_reg.status;
    assign rsp.drive_index     = rsp_reg.drive_index;
    assign rsp.sector_number   = rsp_reg.sector_number;
    assign rsp.head_number     = rsp_reg.head_number;
    assign rsp.cylinder_number = rsp_reg.cylinder_number;
    assign rsp.precomp_byte    = rsp_reg.precomp_byte;
    assign rsp.count_byte      = rsp_reg.count_byte;
    assign rsp.drive_head_byte = rsp_reg.drive_head_byte;
    assign rsp.is_write        = rsp_reg.is_write;

endmodule

// ----- design/btc_table.sv -----
// ----------------------------------------------------------------------------
// btc_table
// Partition start and size memories with a registered read.
// ----------------------------------------------------------------------------
module btc_table #(
    parameter int DEPTH = 128,
    parameter int IDX_W = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [btc_pkg::SECTOR_W-1:0] wr_start,
    input  logic [btc_pkg::SECTOR_W-1:0] wr_size,
    input  logic                        rd_en,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic [btc_pkg::SECTOR_W-1:0] rd_start,
    output logic [btc_pkg::SECTOR_W-1:0] rd_size
);
    import btc_pkg::*;

    logic [SECTOR_W-1:0] start_mem [DEPTH];
    logic [SECTOR_W-1:0] size_mem  [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [SECTOR_W-1:0] start_rd_reg;
    logic [SECTOR_W-1:0] size_rd_reg;
    logic                valid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_start;
            size_mem[wr_addr]  <= wr_size;
        end
        if (rd_en)
        begin
            start_rd_reg <= start_mem[rd_addr];
            size_rd_reg  <= size_mem[rd_addr];
        end
    end

    // size entries read as zero until loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                valid_rd_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_start = start_rd_reg;
    assign rd_size  = valid_rd_reg ? size_rd_reg : '0;

endmodule

// ----- design/btc_divider.sv -----
// ----------------------------------------------------------------------------
// btc_divider
// Restoring divider, one quotient bit per cycle, 33-bit by 8-bit.
// ----------------------------------------------------------------------------
module btc_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [btc_pkg::BLOCK_W-1:0] dividend,
    input  logic [btc_pkg::SPT_W-1:0]   divisor,
    output logic [btc_pkg::BLOCK_W-1:0] quotient,
    output logic [btc_pkg::SPT_W-1:0]   remainder,
    output btc_pkg::div_stat_t          stat
);
    import btc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [BLOCK_W-1:0]   quot_reg;
    logic [SPT_W-1:0]     rem_reg;
    logic [SPT_W-1:0]     div_reg;
    logic [SPT_W:0]       trial;
    logic [SPT_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, quot_reg[BLOCK_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[BLOCK_W-2:0], ge};
            rem_reg  <= ge ? diff[SPT_W-1:0] : trial[SPT_W-1:0];
        end
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- design/btc_checker.sv -----
// ----------------------------------------------------------------------------
// btc_checker
// Port-level checks on the translator, bound to the top level.
// ----------------------------------------------------------------------------
module btc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [btc_pkg::STATUS_W-1:0] rsp_status,
    input logic                         rsp_drive_index,
    input logic [7:0]                   rsp_sector_number,
    input logic [3:0]                   rsp_head_number,
    input logic [15:0]                  rsp_cylinder_number,
    input logic [7:0]                   rsp_drive_head_byte
);
    import btc_pkg::*;

    // one transaction in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a transaction is in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cylinder_number)
            && $stable(rsp_status))
        else $error("stalled response dropped or changed");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_OK |->
            rsp_sector_number != 8'd0
            && rsp_drive_head_byte[3:0] == rsp_head_number
            && rsp_drive_head_byte[4] == rsp_drive_index
            && rsp_drive_head_byte[7:5] == 3'b101)
        else $error("inconsistent task-file fields");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_RANGE || rsp_status == ST_LOADED) |->
            rsp_sector_number == 8'd0 && rsp_cylinder_number == 16'd0
            && rsp_drive_head_byte == 8'd0 && !rsp_drive_index)
        else $error("rejected or load response carries CHS data");

endmodule

bind block_to_chs_task_file_top btc_checker u_btc_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_drive_index     (rsp.drive_index),
    .rsp_sector_number   (rsp.sector_number),
    .rsp_head_number     (rsp.head_number),
    .rsp_cylinder_number (rsp.cylinder_number),
    .rsp_drive_head_byte (rsp.drive_head_byte)
);

// ----- bench/chs_task_file_monitor.sv -----
// ----------------------------------------------------------------------------
// chs_task_file_monitor
// Watches the request, response and register ports of the block to CHS
// translator. It keeps its own partition table and drive geometry and
// computes the task file expected for each accepted request. Each accepted
// response is compared field by field, in order, against the oldest
// expected task file.
// ----------------------------------------------------------------------------
module chs_task_file_monitor #(
    parameter int PARTS_PER_DRIVE = 64,
    parameter int MAX_DRIVES      = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    btc_req_if                             req,
    btc_rsp_if                             rsp,
    input  logic                           cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             errors,
    output int                             pending,
    output int                             n_ok,
    output int                             n_reject,
    output int                             n_ovfl,
    output int                             n_load
);
    import btc_pkg::*;

    localparam int TBL_DEPTH = PARTS_PER_DRIVE * MAX_DRIVES;

    logic [1:0]          drives_cfg;
    logic [SPT_W-1:0]    spt_cfg   [MAX_DRIVES];
    logic [HEADS_W-1:0]  heads_cfg [MAX_DRIVES];
    logic [CYL_W-1:0]    pcomp_cfg [MAX_DRIVES];
    logic [SECTOR_W-1:0] start_tbl [TBL_DEPTH];
    logic [SECTOR_W-1:0] size_tbl  [TBL_DEPTH];
    res_t                task_file_q[$];

    function automatic res_t translate_request(input logic [OPCODE_W-1:0] op,
                                               input logic [MINOR_W-1:0]  minor,
                                               input logic [SECTOR_W-1:0] lba,
                                               input logic [COUNT_W-1:0]  count);
        res_t                r;
        int unsigned         drv;
        logic [SPT_W-1:0]    spt;
        logic [HEADS_W-1:0]  hds;
        logic [BLOCK_W-1:0]  blk;
        logic [BLOCK_W-1:0]  trk;
        logic [BLOCK_W-1:0]  sec;
        logic [BLOCK_W-1:0]  hd;
        logic [BLOCK_W-1:0]  cyl;
        logic [CYL_W-1:0]    pc;
        r = '0;
        if (op == OP_LOAD) begin
            r.status = (minor < TBL_DEPTH) ? ST_LOADED : ST_RANGE;
            return r;
        end
        if (op != OP_READ && op != OP_WRITE) begin
            r.status = ST_RANGE;
            return r;
        end
        r.is_write = (op == OP_WRITE);
        drv = minor / PARTS_PER_DRIVE;
        if (drv >= drives_cfg || drv >= MAX_DRIVES || minor >= TBL_DEPTH
            || lba >= size_tbl[minor]) begin
            r.status = ST_RANGE;
            return r;
        end
        spt = spt_cfg[drv];
        hds = heads_cfg[drv];
        if (spt == 0)
            spt = SPT_W'(1);
        if (hds == 0)
            hds = HEADS_W'(1);
        if (hds > HEADS_MAX)
            hds = HEADS_MAX;
        blk = {1'b0, lba} + {1'b0, start_tbl[minor]};
        sec = blk % spt;
        trk = blk / spt;
        hd  = trk % hds;
        cyl = trk / hds;
        r.drive_index = drv[0];
        if (cyl > {{(BLOCK_W-CYL_W){1'b0}}, {CYL_W{1'b1}}}) begin
            r.status = ST_OVFL;
            return r;
        end
        pc = pcomp_cfg[drv] >> 2;
        r.status          = ST_OK;
        r.sector_number   = sec[BYTE_W-1:0] + 8'd1;
        r.head_number     = hd[HEAD_W-1:0];
        r.cylinder_number = cyl[CYL_W-1:0];
        r.precomp_byte    = pc[BYTE_W-1:0];
        r.count_byte      = count;
        r.drive_head_byte = DRIVE_HEAD_BASE | {3'b000, drv[0], hd[HEAD_W-1:0]};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what,
                 got, want);
        errors++;
    endtask

    task automatic check_task_file(input res_t got);
        res_t want;
        if (task_file_q.size() == 0) begin
            report_mismatch("response with nothing expected, status",
                            32'(got.status), 32'd0);
            return;
        end
        want = task_file_q.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.drive_index !== want.drive_index)
            report_mismatch("drive_index", 32'(got.drive_index),
                            32'(want.drive_index));
        if (got.sector_number !== want.sector_number)
            report_mismatch("sector_number", 32'(got.sector_number),
                            32'(want.sector_number));
        if (got.head_number !== want.head_number)
            report_mismatch("head_number", 32'(got.head_number),
                            32'(want.head_number));
        if (got.cylinder_number !== want.cylinder_number)
            report_mismatch("cylinder_number", 32'(got.cylinder_number),
                            32'(want.cylinder_number));
        if (got.precomp_byte !== want.precomp_byte)
            report_mismatch("precomp_byte", 32'(got.precomp_byte),
                            32'(want.precomp_byte));
        if (got.count_byte !== want.count_byte)
            report_mismatch("count_byte", 32'(got.count_byte),
                            32'(want.count_byte));
        if (got.drive_head_byte !== want.drive_head_byte)
            report_mismatch("drive_head_byte", 32'(got.drive_head_byte),
                            32'(want.drive_head_byte));
        if (got.is_write !== want.is_write)
            report_mismatch("is_write", 32'(got.is_write), 32'(want.is_write));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            drives_cfg = '0;
            for (int d = 0; d < MAX_DRIVES; d++)
            begin
                spt_cfg[d]   = SPT_RESET;
                heads_cfg[d] = HEADS_RESET;
                pcomp_cfg[d] = '0;
            end
            for (int m = 0; m < TBL_DEPTH; m++)
            begin
                start_tbl[m] = '0;
                size_tbl[m]  = '0;
            end
            task_file_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DRIVES:   drives_cfg   = cfg_wdata[1:0];
                    CFG_SPT_D0:   spt_cfg[0]   = cfg_wdata[SPT_W-1:0];
                    CFG_HEADS_D0: heads_cfg[0] = cfg_wdata[HEADS_W-1:0];
                    CFG_SPT_D1:   spt_cfg[1]   = cfg_wdata[SPT_W-1:0];
                    CFG_HEADS_D1: heads_cfg[1] = cfg_wdata[HEADS_W-1:0];
                    CFG_PCOMP_D0: pcomp_cfg[0] = cfg_wdata[CYL_W-1:0];
                    CFG_PCOMP_D1: pcomp_cfg[1] = cfg_wdata[CYL_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                want = translate_request(req.opcode, req.minor_number, req.request_sector,
                                         req.sector_count);
                if (req.opcode == OP_LOAD && req.minor_number < TBL_DEPTH)
                begin
                    start_tbl[req.minor_number] = req.part_start;
                    size_tbl[req.minor_number]  = req.part_size;
                end
                case (want.status)
                    ST_OK:     n_ok++;
                    ST_RANGE:  n_reject++;
                    ST_OVFL:   n_ovfl++;
                    ST_LOADED: n_load++;
                    default: ;
                endcase
                task_file_q.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = '{status: rsp.status, drive_index: rsp.drive_index,
                        sector_number: rsp.sector_number, head_number: rsp.head_number,
                        cylinder_number: rsp.cylinder_number,
                        precomp_byte: rsp.precomp_byte, count_byte: rsp.count_byte,
                        drive_head_byte: rsp.drive_head_byte, is_write: rsp.is_write};
                check_task_file(got);
            end
            pending <= task_file_q.size();
        end
    end

endmodule

// ----- bench/tb_block_to_chs_task_file_top.sv -----
// ----------------------------------------------------------------------------
// tb_block_to_chs_task_file_top
// Stimulus and verdict for the block to CHS task-file translator. A directed
// pass covers geometry extremes, partition bounds, cylinder overflow, absent
// drives and the unused opcode; random passes then load partitions and
// issue mostly in-range requests under several register settings and
// handshake idling patterns, including one long response hold-off.
// ----------------------------------------------------------------------------
module tb_block_to_chs_task_file_top;
    import btc_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
    localparam int TBL_DEPTH   = 128;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 238;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int errors;
    int pending;
    int n_ok;
    int n_reject;
    int n_ovfl;
    int n_load;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int items_sent;
    int settings_used;

    logic [SECTOR_W-1:0] region_size [TBL_DEPTH];
    logic [MINOR_W-1:0]  live_q[$];

    btc_req_if req_ch ();
    btc_rsp_if rsp_ch ();

    block_to_chs_task_file_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    chs_task_file_monitor u_tf_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending),
        .n_ok      (n_ok),
        .n_reject  (n_reject),
        .n_ovfl    (n_ovfl),
        .n_load    (n_load)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("timeout with %0d transactions outstanding", pending);
        $display("status: fail");
        $finish;
    end

    // response side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send(input logic [OPCODE_W-1:0] op, input logic [MINOR_W-1:0] minor,
                        input logic [SECTOR_W-1:0] lba, input logic [COUNT_W-1:0] count,
                        input logic [SECTOR_W-1:0] start, input logic [SECTOR_W-1:0] size);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= op;
        req_ch.minor_number   <= minor;
        req_ch.request_sector <= lba;
        req_ch.sector_count   <= count;
        req_ch.part_start     <= start;
        req_ch.part_size      <= size;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic load_part(input logic [MINOR_W-1:0] minor,
                             input logic [SECTOR_W-1:0] start,
                             input logic [SECTOR_W-1:0] size);
        region_size[minor] = size;
        if (size != 0)
            live_q.push_back(minor);
        send(OP_LOAD, minor, $urandom, $urandom_range(255), start, size);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [1:0] drives,
                                input logic [SPT_W-1:0] spt0, input logic [HEADS_W-1:0] hd0,
                                input logic [SPT_W-1:0] spt1, input logic [HEADS_W-1:0] hd1,
                                input logic [CYL_W-1:0] pc0, input logic [CYL_W-1:0] pc1);
        set_reg(CFG_DRIVES, drives);
        set_reg(CFG_SPT_D0, spt0);
        set_reg(CFG_HEADS_D0, hd0);
        set_reg(CFG_SPT_D1, spt1);
        set_reg(CFG_HEADS_D1, hd1);
        set_reg(CFG_PCOMP_D0, pc0);
        set_reg(CFG_PCOMP_D1, pc1);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [SPT_W-1:0] pick_spt();
        case ($urandom_range(19))
            0:       return '0;
            1, 2:    return 8'd1;
            3, 4:    return 8'd255;
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    function automatic logic [HEADS_W-1:0] pick_heads();
        case ($urandom_range(19))
            0:       return '0;
            1:       return $urandom_range(17, 31);
            2, 3:    return 5'd1;
            4, 5:    return HEADS_MAX;
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic logic [CYL_W-1:0] pick_precomp();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_regs();
        int          r;
        logic [1:0]  drives;
        r = $urandom_range(99);
        drives = (r < 70) ? 2'd2 : (r < 85) ? 2'd1 : 2'd0;
        program_regs(drives, pick_spt(), pick_heads(), pick_spt(), pick_heads(),
                     pick_precomp(), pick_precomp());
    endtask

    task automatic drive_random_item();
        int                  r;
        logic [MINOR_W-1:0]  m;
        logic [SECTOR_W-1:0] st;
        logic [SECTOR_W-1:0] sz;
        logic [SECTOR_W-1:0] lba;
        logic [OPCODE_W-1:0] op;
        r = $urandom_range(99);
        if (r < 18)
        begin
            m = $urandom_range(TBL_DEPTH - 1);
            case ($urandom_range(9))
                0:       st = '0;
                1:       st = '1;
                2, 3:    st = $urandom;
                default: st = $urandom_range(1 << 20);
            endcase
            case ($urandom_range(9))
                0:       sz = '0;
                1:       sz = '1;
                2:       sz = $urandom;
                3:       sz = 1;
                default: sz = $urandom_range(1, 1 << 16);
            endcase
            load_part(m, st, sz);
        end
        else if (r < 22)
            send(OP_RESERVED, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
        begin
            op = $urandom_range(1) ? OP_WRITE : OP_READ;
            if (live_q.size() != 0 && $urandom_range(9) < 8)
                m = live_q[$urandom_range(live_q.size() - 1)];
            else
                m = $urandom_range(TBL_DEPTH - 1);
            sz = region_size[m];
            case ($urandom_range(9))
                0:       lba = sz;
                1:       lba = sz - 1;
                2:       lba = $urandom;
                default: lba = (sz == 0) ? $urandom : $urandom_range(sz - 1, 0);
            endcase
            send(op, m, lba, $urandom_range(255), $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_wdata             <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.opcode         <= OP_LOAD;
        req_ch.minor_number   <= '0;
        req_ch.request_sector <= '0;
        req_ch.sector_count   <= '0;
        req_ch.part_start     <= '0;
        req_ch.part_size      <= '0;
        tx_idle_pct   = 11;
        rx_idle_pct   = 75;
        hold_requests = 0;
        items_sent    = 0;
        settings_used = 1;
        for (int m = 0; m < TBL_DEPTH; m++)
            region_size[m] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no drive present
        send(OP_READ, 7'd0, 32'd0, 8'd1, 32'd0, 32'd0);
        wait_idle();

        program_regs(2'd2, 8'd255, HEADS_MAX, 8'd1, 5'd1, 16'hFFFF, 16'h0000);
        load_part(7'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        load_part(7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        load_part(7'd64, 32'd100, 32'd1000);
        load_part(7'd63, 32'd5, 32'd0);
        send(OP_READ, 7'd0, 32'd0, 8'd0, '0, '0);
        send(OP_WRITE, 7'd0, 32'd267386879, 8'd255, '0, '0);
        send(OP_WRITE, 7'd0, 32'd267386880, 8'd3, '0, '0);
        send(OP_READ, 7'd0, 32'hFFFF_FFFE, 8'd7, '0, '0);
        send(OP_READ, 7'd127, 32'hFFFF_FFFE, 8'd9, '0, '0);
        send(OP_WRITE, 7'd127, 32'hFFFF_FFFF, 8'd9, '0, '0);
        send(OP_READ, 7'd64, 32'd999, 8'd2, '0, '0);
        send(OP_READ, 7'd64, 32'd1000, 8'd2, '0, '0);
        send(OP_WRITE, 7'd63, 32'd0, 8'd1, '0, '0);
        send(OP_RESERVED, 7'h7F, 32'hFFFF_FFFF, 8'hFF, '1, '1);
        send(OP_READ, 7'd5, 32'd0, 8'd1, '0, '0);
        send(OP_WRITE, 7'd0, 32'd12345, 8'h5A, '0, '0);
        wait_idle();

        // zero geometry on drive 0, drive 1 absent
        program_regs(2'd1, 8'd0, 5'd0, 8'd17, 5'd31, 16'd4, 16'hFFFF);
        send(OP_READ, 7'd64, 32'd0, 8'd1, '0, '0);
        send(OP_READ, 7'd0, 32'd65535, 8'd1, '0, '0);
        send(OP_WRITE, 7'd0, 32'd65536, 8'd1, '0, '0);
        wait_idle();

        // head counts above the maximum on both drives
        program_regs(2'd2, 8'd63, 5'd17, 8'd255, 5'd31, 16'h1234, 16'd3);
        send(OP_READ, 7'd64, 32'd500, 8'd1, '0, '0);
        send(OP_WRITE, 7'd0, 32'd777, 8'd128, '0, '0);
        send(OP_READ, 7'd127, 32'd5, 8'd64, '0, '0);

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 75 : 0;
            rx_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 11 : 0;
            for (int blk = 0; blk < 2; blk++)
            begin
                wait_idle();
                random_regs();
                if (ph == 0 && blk == 0)
                    hold_requests++;
                repeat (RAND_ITEMS) drive_random_item();
            end
        end
        wait_idle();
        repeat (100) @(posedge clk);

        $display("covered %0d transactions over %0d register settings", items_sent,
                 settings_used);
        $display("  %0d translated, %0d rejected, %0d cylinder overflow, %0d loads",
                 n_ok, n_reject, n_ovfl, n_load);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
